>>> rtl/core/uxr_pkg.sv
// Shared types and constants for the UART receive ring with XON/XOFF filtering.
package uxr_pkg;

	// Item operation codes
	typedef enum logic [1:0] {
		OP_RX    = 2'd0,
		OP_READ  = 2'd1,
		OP_FLUSH = 2'd2
	} op_t;

	// Configuration register indexes
	typedef enum logic {
		CFG_FC_ENABLE = 1'b0,
		CFG_PROBE     = 1'b1
	} cfg_idx_t;

	localparam logic [7:0] XON_CODE  = 8'h11;
	localparam logic [7:0] XOFF_CODE = 8'h13;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic take;      // item accepted this cycle, apply its operation
		logic load_now;  // load result register with a result that needs no ring read
		logic load_mem;  // load result register with the byte read from the ring
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_full;    // result register holds an item not yet taken
		logic ring_empty;  // read index equals write index
	} status_t;

endpackage

>>> rtl/core/uxr_ctrl.sv
// Controller state machine: accepts items and sequences ring reads.
module uxr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              out_ready,
	input  logic [1:0]        operation,
	input  uxr_pkg::status_t  status,
	output uxr_pkg::cmd_t     cmd
);

	uxr_pkg::state_t state_q;
	uxr_pkg::state_t state_d;
	logic            take;
	logic            read_hit;

	assign in_ready = (state_q == uxr_pkg::ST_IDLE) && (!status.out_full || out_ready);
	assign take     = in_valid && in_ready;
	assign read_hit = (operation == uxr_pkg::OP_READ) && !status.ring_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= uxr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			uxr_pkg::ST_IDLE: begin
				if (take && read_hit) begin
					state_d = uxr_pkg::ST_READ;
				end
			end
			uxr_pkg::ST_READ: begin
				state_d = uxr_pkg::ST_IDLE;
			end
			default: begin
				state_d = uxr_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			uxr_pkg::ST_IDLE: begin
				cmd.take     = take;
				cmd.load_now = take && !read_hit;
			end
			uxr_pkg::ST_READ: begin
				cmd.load_mem = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

>>> rtl/core/uxr_datapath.sv
// Datapath: ring memory, indexes, flow-control filter, config and result register.
module uxr_datapath #(
	parameter int RING_DEPTH = 512,
	localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1,
	localparam int PK_W  = $clog2(RING_DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  uxr_pkg::cmd_t     cmd,
	output uxr_pkg::status_t  status,
	input  logic [1:0]        operation,
	input  logic [7:0]        rx_byte,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [7:0]        cfg_data,
	input  logic              out_ready,
	output logic              out_valid,
	output logic              read_ok,
	output logic [7:0]        read_byte,
	output logic              peer_stopped,
	output logic [PK_W-1:0]   high_watermark
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

	logic [7:0]       ring_mem [RING_DEPTH];
	logic [7:0]       rdata_q;
	logic [IDX_W-1:0] wr_idx_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic             stop_q;
	logic [PK_W-1:0]  peak_q;
	logic             fc_en_q;
	logic [7:0]       probe_q;
	logic             out_valid_q;
	logic             read_ok_q;
	logic [7:0]       read_byte_q;
	logic             stopped_q;
	logic [PK_W-1:0]  watermark_q;

	logic             stop_d;
	logic [PK_W-1:0]  peak_d;
	logic [PK_W-1:0]  wr_inc;
	logic             do_store;
	logic             do_read;

	assign status.out_full   = out_valid_q;
	assign status.ring_empty = (rd_idx_q == wr_idx_q);

	assign wr_inc = PK_W'(wr_idx_q) + PK_W'(1);

	// Decode the item's effect on the stop flag, the store and the read side
	always_comb begin
		stop_d   = stop_q;
		peak_d   = peak_q;
		do_store = 1'b0;
		do_read  = 1'b0;
		case (operation)
			uxr_pkg::OP_RX: begin
				if (fc_en_q && rx_byte == uxr_pkg::XON_CODE) begin
					stop_d = 1'b0;
				end else if (fc_en_q && rx_byte == uxr_pkg::XOFF_CODE) begin
					stop_d = 1'b1;
				end else if (!(fc_en_q && rx_byte == probe_q)) begin
					do_store = 1'b1;
					if (wr_inc > peak_q) begin
						peak_d = wr_inc;
					end
				end
			end
			uxr_pkg::OP_READ: begin
				do_read = !status.ring_empty;
			end
			default: begin
				do_read = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.take && do_store) begin
			ring_mem[wr_idx_q] <= rx_byte;
		end
		if (cmd.take && do_read) begin
			rdata_q <= ring_mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			stop_q   <= 1'b0;
			peak_q   <= '0;
		end else if (cmd.take) begin
			stop_q <= stop_d;
			peak_q <= peak_d;
			if (operation == uxr_pkg::OP_FLUSH) begin
				wr_idx_q <= '0;
				rd_idx_q <= '0;
			end
			if (do_store) begin
				wr_idx_q <= (wr_idx_q == LAST_IDX) ? '0 : wr_idx_q + IDX_W'(1);
			end
			if (do_read) begin
				rd_idx_q <= (rd_idx_q == LAST_IDX) ? '0 : rd_idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_en_q <= 1'b0;
			probe_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				uxr_pkg::CFG_FC_ENABLE: fc_en_q <= cfg_data[0];
				uxr_pkg::CFG_PROBE:     probe_q <= cfg_data;
				default:                probe_q <= probe_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_now || cmd.load_mem) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_now) begin
			read_ok_q   <= 1'b0;
			read_byte_q <= '0;
			stopped_q   <= stop_d;
			watermark_q <= peak_d;
		end else if (cmd.load_mem) begin
			read_ok_q   <= 1'b1;
			read_byte_q <= rdata_q;
			stopped_q   <= stop_q;
			watermark_q <= peak_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign read_ok        = read_ok_q;
	assign read_byte      = read_byte_q;
	assign peer_stopped   = stopped_q;
	assign high_watermark = watermark_q;

	a_mem_load_free : assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_mem |-> !out_valid_q)
		else $error("ring read result would overwrite a pending item");

	a_read_follows : assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && do_read) |=> cmd.load_mem)
		else $error("launched ring read not delivered in the next cycle");

	a_mem_after_read : assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_mem |-> $past(cmd.take && do_read))
		else $error("result loaded from memory without a launched read");

	a_single_load : assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load_now && cmd.load_mem))
		else $error("two result loads in one cycle");

endmodule

>>> rtl/core/uart_rx_ring_xon_xoff_unit.sv
// Top level of the UART receive ring buffer with XON/XOFF software flow control.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item: operation and rx_byte.
//   operation 0 stores rx_byte (or, with flow control on, takes XON/XOFF into
//   the stop flag and drops the probe byte), 1 reads the oldest byte, 2 flushes.
//   Every item gives exactly one result on the output channel
//   (out_valid/out_ready): read_ok, read_byte, peer_stopped, high_watermark.
//   Configuration is a plain write port: cfg_we, cfg_index (0 flow-control
//   enable, 1 probe byte), cfg_data. Write it only while no item is in flight.
// Result path and throughput:
//   A receive, flush or empty read puts its result in the output register
//   in the cycle after acceptance; one item per cycle while results are taken.
//   A read that returns a byte also passes the ring memory's registered read
//   port and the ST_READ state, in which no new item is accepted.
// Reset (arst_n low): indexes, stop flag, watermark and config clear at once;
//   the ring contents are left as they are and are never read before written.
// Stall: a result waits in the output register; one further item is accepted
//   in that cycle only when out_ready takes the waiting result.
module uart_rx_ring_xon_xoff_unit #(
	parameter int RING_DEPTH = 512
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         operation,
	input  logic [7:0]                         rx_byte,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               read_ok,
	output logic [7:0]                         read_byte,
	output logic                               peer_stopped,
	output logic [$clog2(RING_DEPTH + 1)-1:0]  high_watermark,
	input  logic                               cfg_we,
	input  logic                               cfg_index,
	input  logic [7:0]                         cfg_data
);

	// Command and status between the sequencer and the datapath
	uxr_pkg::cmd_t    cmd;
	uxr_pkg::status_t status;

	// Sequencer: gates acceptance and steps a ring read through the ST_READ state
	uxr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.operation (operation),
		.status    (status),
		.cmd       (cmd)
	);

	// Ring memory, indexes, flow-control filter and result register
	uxr_datapath #(
		.RING_DEPTH (RING_DEPTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.operation      (operation),
		.rx_byte        (rx_byte),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.read_ok        (read_ok),
		.read_byte      (read_byte),
		.peer_stopped   (peer_stopped),
		.high_watermark (high_watermark)
	);

endmodule

>>> sim/tb_uart_rx_ring_xon_xoff_unit.sv
// Testbench for the UART receive ring with XON/XOFF filtering, checked against a local model.
`timescale 1ns / 1ps

module tb_uart_rx_ring_xon_xoff_unit;

	localparam int DEPTH = 512;
	localparam int PEAK_W = $clog2(DEPTH + 1);
	// Operation code that the package leaves undefined; the block must ignore it
	localparam logic [1:0] OP_UNUSED = 2'd3;
	// Result number after which the receiver holds off, and for how long
	localparam int unsigned LONG_HOLD_AT = 200;
	localparam int unsigned LONG_HOLD_CYCLES = 300;
	localparam int unsigned CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data;
	} rx_item_t;

	typedef struct packed {
		logic              ok;
		logic [7:0]        data;
		logic              stopped;
		logic [PEAK_W-1:0] peak;
	} ring_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [1:0]        operation = uxr_pkg::OP_RX;
	logic [7:0]        rx_byte = 8'h00;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              read_ok;
	logic [7:0]        read_byte;
	logic              peer_stopped;
	logic [PEAK_W-1:0] high_watermark;
	logic              cfg_we = 1'b0;
	logic              cfg_index = uxr_pkg::CFG_FC_ENABLE;
	logic [7:0]        cfg_data = 8'h00;

	uart_rx_ring_xon_xoff_unit #(
		.RING_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_ok(read_ok),
		.read_byte(read_byte),
		.peer_stopped(peer_stopped),
		.high_watermark(high_watermark),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Items waiting to be offered, and results owed by the block in order
	rx_item_t     item_queue[$];
	ring_result_t expected_results[$];

	// Local copy of the ring state and of the two registers
	logic [7:0]        ring_copy[DEPTH];
	int unsigned       wr_pos = 0;
	int unsigned       rd_pos = 0;
	logic              stop_copy = 1'b0;
	logic [PEAK_W-1:0] peak_copy = '0;
	logic              fc_enable_copy = 1'b0;
	logic [7:0]        probe_copy = 8'h00;

	int unsigned mismatch_count = 0;
	int unsigned results_seen = 0;
	int unsigned cycle_count = 0;
	int unsigned send_gap = 0;
	int unsigned send_calm = 0;
	int unsigned take_wait = 0;
	int unsigned take_calm = 0;

	// Apply one item to the local ring and return the result it must produce.
	// With flow control on, XON and XOFF win over a probe byte of the same value.
	function automatic ring_result_t ring_predict(logic [1:0] op, logic [7:0] b);
		ring_result_t r;
		r = '0;
		case (op)
			uxr_pkg::OP_RX: begin
				if (fc_enable_copy && b == uxr_pkg::XON_CODE)
					stop_copy = 1'b0;
				else if (fc_enable_copy && b == uxr_pkg::XOFF_CODE)
					stop_copy = 1'b1;
				else if (!(fc_enable_copy && b == probe_copy)) begin
					ring_copy[wr_pos] = b;
					if (wr_pos + 1 > peak_copy)
						peak_copy = PEAK_W'(wr_pos + 1);
					wr_pos = (wr_pos == DEPTH - 1) ? 0 : wr_pos + 1;
				end
			end
			uxr_pkg::OP_READ: begin
				// Equal indexes mean empty, also right after an overrun
				if (rd_pos != wr_pos) begin
					r.ok = 1'b1;
					r.data = ring_copy[rd_pos];
					rd_pos = (rd_pos == DEPTH - 1) ? 0 : rd_pos + 1;
				end
			end
			uxr_pkg::OP_FLUSH: begin
				// Stop flag and watermark survive a flush
				wr_pos = 0;
				rd_pos = 0;
			end
			default: ;
		endcase
		r.stopped = stop_copy;
		r.peak = peak_copy;
		return r;
	endfunction

	// Bias received bytes toward the ones that flow control acts on
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return uxr_pkg::XON_CODE;
			1: return uxr_pkg::XOFF_CODE;
			2: return probe_copy;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic push_item(logic [1:0] op, logic [7:0] b);
		rx_item_t it;
		it.op = op;
		it.data = b;
		item_queue.push_back(it);
	endtask

	// Queue n random items: rx_pct percent receives, flush_pct flushes, a few
	// unused codes, reads for the rest.
	task automatic queue_random(int n, int rx_pct, int flush_pct);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < rx_pct)
				push_item(uxr_pkg::OP_RX, pick_byte());
			else if (r < rx_pct + flush_pct)
				push_item(uxr_pkg::OP_FLUSH, 8'($urandom_range(0, 255)));
			else if (r < rx_pct + flush_pct + 2)
				push_item(OP_UNUSED, 8'($urandom_range(0, 255)));
			else
				push_item(uxr_pkg::OP_READ, 8'($urandom_range(0, 255)));
		end
	endtask

	// Write one register; only called while nothing is in flight
	task automatic write_cfg(uxr_pkg::cfg_idx_t idx, logic [7:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == uxr_pkg::CFG_FC_ENABLE)
			fc_enable_copy = val[0];
		else
			probe_copy = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Hold the sender until every queued item is accepted and every result
	// is back, then let the block return to idle.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (item_queue.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	// Sender: offer queued items, predict each one at acceptance, then idle
	// for a drawn number of cycles. Calm stretches offer back to back.
	always @(posedge clk or negedge arst_n) begin : drive_items
		rx_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			operation <= uxr_pkg::OP_RX;
			rx_byte <= 8'h00;
			send_gap <= 0;
			send_calm <= 0;
		end else begin
			if (in_valid && in_ready)
				expected_results.push_back(ring_predict(operation, rx_byte));
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (item_queue.size() != 0) begin
					nxt = item_queue.pop_front();
					operation <= nxt.op;
					rx_byte <= nxt.data;
					in_valid <= 1'b1;
					send_gap <= (send_calm != 0) ? 0 : $urandom_range(0, 11);
					send_calm <= (send_calm != 0) ? send_calm - 1 :
						(($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : 0);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each result against the oldest expectation, then stall
	// for a drawn number of cycles. Once, hold off long enough that the output
	// register fills and the input stalls while the sender keeps offering.
	always @(posedge clk or negedge arst_n) begin : take_results
		ring_result_t want;
		ring_result_t got;
		int unsigned hold;
		if (!arst_n) begin
			out_ready <= 1'b0;
			take_wait <= 0;
			take_calm <= 0;
			results_seen <= 0;
		end else begin
			hold = take_wait;
			if (out_valid && out_ready) begin
				got = {read_ok, read_byte, peer_stopped, high_watermark};
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"result %0d with nothing expected: ",
							"ok=%0d byte=%02h stop=%0d peak=%0d"},
							results_seen, got.ok, got.data, got.stopped, got.peak);
				end else begin
					want = expected_results.pop_front();
					if (got.ok !== want.ok || got.data !== want.data
						|| got.stopped !== want.stopped || got.peak !== want.peak) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display({"result %0d: expected ok=%0d byte=%02h stop=%0d ",
								"peak=%0d, got ok=%0d byte=%02h stop=%0d peak=%0d"},
								results_seen, want.ok, want.data, want.stopped,
								want.peak, got.ok, got.data, got.stopped, got.peak);
					end
				end
				results_seen <= results_seen + 1;
				hold = (take_calm != 0) ? 0 : $urandom_range(0, 11);
				if (results_seen == LONG_HOLD_AT)
					hold = LONG_HOLD_CYCLES;
				take_calm <= (take_calm != 0) ? take_calm - 1 :
					(($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : 0);
			end
			if (hold != 0) begin
				out_ready <= 1'b0;
				take_wait <= hold - 1;
			end else begin
				out_ready <= 1'b1;
				take_wait <= 0;
			end
		end
	end

	// Guard against a hung handshake
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("uart_rx_ring_xon_xoff_unit: mismatch");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Flow control off: XON, XOFF and probe values are stored as data;
		// a read of an empty ring, the unused code and a flush are included.
		write_cfg(uxr_pkg::CFG_FC_ENABLE, 8'h00);
		write_cfg(uxr_pkg::CFG_PROBE, 8'hFF);
		push_item(uxr_pkg::OP_READ, 8'h00);
		push_item(uxr_pkg::OP_RX, 8'h00);
		push_item(uxr_pkg::OP_RX, 8'hFF);
		push_item(uxr_pkg::OP_RX, uxr_pkg::XON_CODE);
		push_item(uxr_pkg::OP_RX, uxr_pkg::XOFF_CODE);
		push_item(OP_UNUSED, 8'hFF);
		repeat (4) push_item(uxr_pkg::OP_READ, 8'hFF);
		push_item(uxr_pkg::OP_READ, 8'h00);
		push_item(uxr_pkg::OP_RX, 8'h5A);
		push_item(uxr_pkg::OP_FLUSH, 8'h00);
		push_item(uxr_pkg::OP_READ, 8'h00);
		wait_drained();

		// Flow control on with the probe equal to XOFF: XOFF meaning wins;
		// the stop flag must survive a flush.
		write_cfg(uxr_pkg::CFG_FC_ENABLE, 8'h01);
		write_cfg(uxr_pkg::CFG_PROBE, uxr_pkg::XOFF_CODE);
		push_item(uxr_pkg::OP_RX, uxr_pkg::XOFF_CODE);
		push_item(uxr_pkg::OP_RX, 8'h42);
		push_item(uxr_pkg::OP_FLUSH, 8'h00);
		push_item(uxr_pkg::OP_RX, uxr_pkg::XON_CODE);
		push_item(uxr_pkg::OP_READ, 8'h00);
		wait_drained();

		// Probe byte at zero is dropped, other bytes pass
		write_cfg(uxr_pkg::CFG_PROBE, 8'h00);
		push_item(uxr_pkg::OP_RX, 8'h00);
		push_item(uxr_pkg::OP_RX, 8'hFF);
		push_item(uxr_pkg::OP_READ, 8'h00);
		push_item(uxr_pkg::OP_READ, 8'h00);
		wait_drained();

		// Random phases; each one ends with the sender paused until drained
		write_cfg(uxr_pkg::CFG_FC_ENABLE, 8'h00);
		queue_random(250, 50, 3);
		wait_drained();

		// Long run of receives without flush: the watermark reaches the full
		// depth, the write index wraps and overruns unread data.
		write_cfg(uxr_pkg::CFG_PROBE, 8'hFF);
		queue_random(600, 95, 0);
		wait_drained();

		write_cfg(uxr_pkg::CFG_FC_ENABLE, 8'h01);
		write_cfg(uxr_pkg::CFG_PROBE, 8'($urandom_range(0, 255)));
		queue_random(300, 50, 3);
		wait_drained();

		// Probe equal to XON: XON must still clear the stop flag
		write_cfg(uxr_pkg::CFG_PROBE, uxr_pkg::XON_CODE);
		queue_random(250, 52, 2);
		wait_drained();

		write_cfg(uxr_pkg::CFG_PROBE, 8'hFF);
		queue_random(250, 55, 2);
		wait_drained();

		write_cfg(uxr_pkg::CFG_FC_ENABLE, 8'h00);
		write_cfg(uxr_pkg::CFG_PROBE, uxr_pkg::XOFF_CODE);
		queue_random(250, 50, 3);
		wait_drained();

		write_cfg(uxr_pkg::CFG_FC_ENABLE, 8'h01);
		write_cfg(uxr_pkg::CFG_PROBE, 8'h00);
		queue_random(200, 50, 3);
		wait_drained();

		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("uart_rx_ring_xon_xoff_unit: match");
		else
			$display("uart_rx_ring_xon_xoff_unit: mismatch");
		$finish;
	end

endmodule
